>>> sv/ufrc_pkg.sv
// Shared types and constants for the union-find engine.
`timescale 1ns / 1ps
package ufrc_pkg;

  // Fixed field widths: node index in a transaction, rank in a memory word.
  localparam int NODE_W = 10;
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // Request codes.
  localparam logic REQ_FIND  = 1'b0;
  localparam logic REQ_UNION = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } ufrc_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] root_out;
    logic              merged;
  } ufrc_res_t;

endpackage

>>> sv/ufrc_ram.sv
// Single-write, single-read node memory with registered read data.
`timescale 1ns / 1ps
module ufrc_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 14
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; a read at the written address returns the old word.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/union_find_rank_compress.sv
// Top level of the union-find engine: sequencer around one node memory.
//
//  channel   | handshake          | payload        | notes
//  ----------+--------------------+----------------+-------------------------------
//  request   | start, busy        | req  (ufrc_req_t) | taken when start & !busy
//  result    | done               | res  (ufrc_res_t) | valid one cycle, no stall
//
// A find reads the memory on the way up from the accepted node to the root, then
// rewrites each node on the path to point at the root (compression), then passes a
// decision state, after which the result is registered on done. A union runs two
// finds back to back and then, when the roots differ, a link write and possibly a rank write.
// After reset a clearing pass writes every entry with busy high.
// The receiver cannot stall: each result is shown for exactly one cycle on done.
module union_find_rank_compress #(
  parameter int NODES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ufrc_pkg::ufrc_req_t req,
  output logic                done,
  output ufrc_pkg::ufrc_res_t res
);

  import ufrc_pkg::*;

  localparam int IDX_W  = $clog2(NODES);
  localparam int WORD_W = RANK_W + IDX_W;
  localparam int CMP_W  = 17;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_COMP = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_LINK = 3'd5;
  localparam logic [2:0] S_BUMP = 3'd6;

  logic [2:0]        state;
  logic [IDX_W-1:0]  clr_cnt;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  cur_next;
  logic [IDX_W-1:0]  start_node;
  logic [IDX_W-1:0]  node_b_cl;
  logic [IDX_W-1:0]  root;
  logic [RANK_W-1:0] root_rank;
  logic [IDX_W-1:0]  ra;
  logic [RANK_W-1:0] rank_a;
  logic              is_union;
  logic              phase_b;

  logic [IDX_W-1:0]  a_cl;
  logic [IDX_W-1:0]  b_cl;
  logic [IDX_W-1:0]  rd_parent;
  logic [RANK_W-1:0] rd_rank;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              a_low;
  logic [IDX_W-1:0]  hi_node;
  logic [IDX_W-1:0]  lo_node;
  logic [RANK_W-1:0] hi_rank;
  logic [RANK_W-1:0] lo_rank;

  // Saturate request indices at the last node.
  always_comb begin
    if (CMP_W'(req.node_a) >= CMP_W'(NODES)) begin
      a_cl = IDX_W'(NODES - 1);
    end else begin
      a_cl = IDX_W'(req.node_a);
    end
    if (CMP_W'(req.node_b) >= CMP_W'(NODES)) begin
      b_cl = IDX_W'(NODES - 1);
    end else begin
      b_cl = IDX_W'(req.node_b);
    end
  end

  assign rd_parent = rd_data[IDX_W-1:0];
  assign rd_rank   = rd_data[WORD_W-1:IDX_W];

  // Link order: the lower-rank root goes under the other, ties under a's root.
  assign a_low   = (rank_a < root_rank);
  assign hi_node = a_low ? root : ra;
  assign lo_node = a_low ? ra : root;
  assign hi_rank = a_low ? root_rank : rank_a;
  assign lo_rank = a_low ? rank_a : root_rank;

  assign busy = (state != S_IDLE);

  // Next walk address; the memory is always read there so data for cur is ready.
  always_comb begin
    cur_next = cur;
    case (state)
      S_IDLE: begin
        if (start) begin
          cur_next = a_cl;
        end
      end
      S_WALK: begin
        if (rd_parent == cur) begin
          cur_next = start_node;
        end else begin
          cur_next = rd_parent;
        end
      end
      S_COMP: begin
        cur_next = rd_parent;
      end
      S_FIN: begin
        if (!phase_b && is_union) begin
          cur_next = node_b_cl;
        end
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  // Memory writes: clearing pass, path rewrite, link and rank bump.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = {rd_rank, root};
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = {{RANK_W{1'b0}}, clr_cnt};
      end
      S_COMP: begin
        wr_en   = 1'b1;
        wr_addr = cur;
        wr_data = {rd_rank, root};
      end
      S_LINK: begin
        wr_en   = 1'b1;
        wr_addr = lo_node;
        wr_data = {lo_rank, hi_node};
      end
      S_BUMP: begin
        wr_en   = 1'b1;
        wr_addr = root;
        wr_data = {root_rank, root};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  ufrc_ram #(
    .DEPTH(NODES),
    .AW   (IDX_W),
    .DW   (WORD_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(cur_next),
    .rd_data(rd_data)
  );

  // Walk pointer follows the address that was read.
  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == IDX_W'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            start_node <= a_cl;
            node_b_cl  <= b_cl;
            is_union   <= (req.req_type == REQ_UNION);
            phase_b    <= 1'b0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_parent == cur) begin
            root      <= cur;
            root_rank <= rd_rank;
            if (cur == start_node) begin
              state <= S_FIN;
            end else begin
              state <= S_COMP;
            end
          end
        end
        S_COMP: begin
          if (rd_parent == root) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!phase_b) begin
            ra     <= root;
            rank_a <= root_rank;
            if (is_union) begin
              start_node <= node_b_cl;
              phase_b    <= 1'b1;
              state      <= S_WALK;
            end else begin
              res.root_out <= NODE_W'(root);
              res.merged   <= 1'b0;
              done         <= 1'b1;
              state        <= S_IDLE;
            end
          end else if (ra == root) begin
            res.root_out <= NODE_W'(ra);
            res.merged   <= 1'b0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          root      <= hi_node;
          root_rank <= hi_rank + 1'b1;
          if ((hi_rank == lo_rank) && (hi_rank != RANK_MAX)) begin
            state <= S_BUMP;
          end else begin
            res.root_out <= NODE_W'(hi_node);
            res.merged   <= 1'b1;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_BUMP: begin
          res.root_out <= NODE_W'(root);
          res.merged   <= 1'b1;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only closes a transaction that was in progress.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != S_IDLE))
    else $error("result strobe without a transaction in progress");

  // An accepted request never produces a result in the next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result one cycle after accept");

  // Only a union can report a merge.
  a_merge_is_union: assert property (@(posedge clk) disable iff (rst)
    (done && res.merged) |-> is_union)
    else $error("merge reported for a find request");

  // The node memory is left alone while waiting for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("memory written while idle");

endmodule
